@@ sv/apd_pkg.sv @@
// Shared constants for the action potential duration meter.
`timescale 1ns / 1ps

package apd_pkg;

    // Configuration port
    localparam int CFG_DATA_WIDTH  = 16;
    localparam int CFG_INDEX_WIDTH = 2;
    localparam int PCT_WIDTH       = 7;

    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_REST_INITIAL   = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_UPSTROKE_LEVEL = 2'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_PEAK_WINDOW    = 2'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_REPOL_PERCENT  = 2'd3;

    // Register reset values
    localparam logic signed [CFG_DATA_WIDTH-1:0] REST_INITIAL_RESET   = -16'sd21760;
    localparam logic signed [CFG_DATA_WIDTH-1:0] UPSTROKE_LEVEL_RESET = -16'sd10240;
    localparam logic [CFG_DATA_WIDTH-1:0]        PEAK_WINDOW_RESET    = 16'd100;
    localparam logic [PCT_WIDTH-1:0]             REPOL_PERCENT_RESET  = 7'd90;

    // Percent scale
    localparam int REPOL_SCALE = 100;

    // Duration output
    localparam int                 DUR_WIDTH = 32;
    localparam logic [DUR_WIDTH-1:0] DUR_MAX = 32'hFFFF_FFFF;

    // Phase codes
    localparam logic [1:0] PH_SEARCH = 2'd0;
    localparam logic [1:0] PH_AMPL   = 2'd1;
    localparam logic [1:0] PH_END    = 2'd2;

endpackage

@@ sv/apd_if.sv @@
// Sample and result stream interfaces of the action potential duration meter.
`timescale 1ns / 1ps

interface apd_sample_if #(
    parameter int SAMPLE_WIDTH = 16
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] voltage;

    modport source (output valid, output voltage, input ready);
    modport sink   (input valid, input voltage, output ready);
endinterface

interface apd_result_if
    import apd_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 16
);
    logic                           valid;
    logic                           ready;
    logic [DUR_WIDTH-1:0]           duration_steps;
    logic signed [SAMPLE_WIDTH-1:0] peak_level;
    logic signed [SAMPLE_WIDTH-1:0] rest_level;

    modport source (output valid, output duration_steps, output peak_level,
                    output rest_level, input ready);
    modport sink   (input valid, input duration_steps, input peak_level,
                    input rest_level, output ready);
endinterface

@@ sv/apd_core.sv @@
// Phase tracking, peak window, end threshold compare, one sample per step cycle.
`timescale 1ns / 1ps

module apd_core
    import apd_pkg::*;
#(
    parameter int COUNT_WIDTH  = 32,
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [CFG_INDEX_WIDTH-1:0]     cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0]      cfg_data,
    input  logic                           step,
    input  logic signed [SAMPLE_WIDTH-1:0] voltage,
    output logic                           res_valid,
    output logic [DUR_WIDTH-1:0]           res_duration,
    output logic signed [SAMPLE_WIDTH-1:0] res_peak,
    output logic signed [SAMPLE_WIDTH-1:0] res_rest
);

    localparam int SW = SAMPLE_WIDTH;
    localparam int CW = COUNT_WIDTH;
    // compare width for sample against 16-bit register values
    localparam int WW = ((SW > CFG_DATA_WIDTH) ? SW : CFG_DATA_WIDTH) + 1;
    // product width: (SW+1)-bit amplitude times 8-bit signed percent
    localparam int PW = SW + 9;
    localparam int DW = (CW > CFG_DATA_WIDTH) ? CW : CFG_DATA_WIDTH;
    localparam int XW = (CW > DUR_WIDTH) ? CW : DUR_WIDTH + 1;

    localparam logic signed [WW-1:0] S_HI = {{(WW-SW+1){1'b0}}, {(SW-1){1'b1}}};
    localparam logic signed [WW-1:0] S_LO = ~S_HI;
    localparam logic signed [SW-1:0] V_LO = {1'b1, {(SW-1){1'b0}}};

    function automatic logic signed [SW-1:0] sat_sample(input logic signed [CFG_DATA_WIDTH-1:0] x);
        logic signed [WW-1:0] xe;
        logic signed [SW-1:0] r;
        xe = WW'(x);
        if (xe > S_HI)
            r = S_HI[SW-1:0];
        else if (xe < S_LO)
            r = S_LO[SW-1:0];
        else
            r = xe[SW-1:0];
        return r;
    endfunction

    // Configuration registers
    logic signed [CFG_DATA_WIDTH-1:0] upstroke_reg;
    logic [CFG_DATA_WIDTH-1:0]        window_reg;
    logic [PCT_WIDTH-1:0]             percent_reg;

    // State
    logic [1:0]             phase_reg, phase_next;
    logic signed [SW-1:0]   rest_reg, rest_next;
    logic signed [SW-1:0]   peak_reg, peak_next;
    logic [CW-1:0]          step_reg, step_next;
    logic [CW-1:0]          peak_step_reg, peak_step_next;
    logic signed [PW-1:0]   prod_reg, prod_next;

    logic [CW-1:0]          step_base;
    logic                   hit;

    logic                   v_gt_peak;
    logic                   v_le_rest;
    logic                   v_ge_up;
    logic [CW-1:0]          gap;
    logic                   gap_over;
    logic signed [SW:0]     amp;
    logic signed [PW-1:0]   prod_calc;
    logic signed [PW-1:0]   drop_scaled;
    logic signed [PW-1:0]   head_scaled;
    logic                   lo_case;
    logic                   end_hit;
    logic [XW-1:0]          step_x;

    assign v_gt_peak = voltage > peak_reg;
    assign v_le_rest = voltage <= rest_reg;
    assign v_ge_up   = WW'(voltage) >= WW'(upstroke_reg);

    assign gap      = step_reg - peak_step_reg;
    assign gap_over = DW'(gap) > DW'(window_reg);

    assign amp       = (SW+1)'(peak_reg) - (SW+1)'(rest_reg);
    assign prod_calc = PW'(amp) * PW'(signed'({1'b0, percent_reg}));

    // v <= peak - ceil(prod/100)  <=>  prod <= 100 * (peak - v)
    assign drop_scaled = PW'((SW+1)'(peak_reg) - (SW+1)'(voltage)) * PW'(REPOL_SCALE);
    // threshold below the sample range saturates to the minimum
    assign head_scaled = (PW'(peak_reg) - PW'(V_LO)) * PW'(REPOL_SCALE);
    assign lo_case     = prod_reg > head_scaled;
    assign end_hit     = lo_case ? (voltage == V_LO) : (prod_reg <= drop_scaled);

    always_comb
    begin
        phase_next     = phase_reg;
        rest_next      = rest_reg;
        peak_next      = peak_reg;
        peak_step_next = peak_step_reg;
        prod_next      = prod_reg;
        step_base      = step_reg;
        hit            = 1'b0;
        unique case (phase_reg)
            PH_AMPL:
            begin
                if (v_gt_peak)
                begin
                    peak_next      = voltage;
                    peak_step_next = step_reg;
                end
                else if (gap_over)
                begin
                    prod_next  = prod_calc;
                    phase_next = PH_END;
                end
            end
            PH_END:
            begin
                if (end_hit)
                begin
                    hit        = 1'b1;
                    phase_next = PH_SEARCH;
                end
            end
            PH_SEARCH:
            begin
                if (v_le_rest)
                    rest_next = voltage;
                if (v_ge_up)
                begin
                    phase_next     = PH_AMPL;
                    step_base      = '0;
                    peak_step_next = '0;
                    peak_next      = voltage;
                end
            end
            default:
            begin
                phase_next = PH_SEARCH;
            end
        endcase
        step_next = (step_base == {CW{1'b1}}) ? step_base : step_base + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upstroke_reg  <= UPSTROKE_LEVEL_RESET;
            window_reg    <= PEAK_WINDOW_RESET;
            percent_reg   <= REPOL_PERCENT_RESET;
            phase_reg     <= PH_SEARCH;
            rest_reg      <= sat_sample(REST_INITIAL_RESET);
            peak_reg      <= '0;
            step_reg      <= '0;
            peak_step_reg <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index)
                    CFG_REST_INITIAL:   ;
                    CFG_UPSTROKE_LEVEL: upstroke_reg  <= cfg_data;
                    CFG_PEAK_WINDOW:    window_reg    <= cfg_data;
                    CFG_REPOL_PERCENT:  percent_reg   <= cfg_data[PCT_WIDTH-1:0];
                    default:            ;
                endcase
            end
            // rest_initial loads the resting level directly
            if (cfg_write && cfg_index == CFG_REST_INITIAL)
                rest_reg <= sat_sample(cfg_data);
            else if (step)
                rest_reg <= rest_next;
            if (step)
            begin
                phase_reg     <= phase_next;
                peak_reg      <= peak_next;
                step_reg      <= step_next;
                peak_step_reg <= peak_step_next;
            end
        end
    end

    // frozen product for the end phase
    always_ff @(posedge clk)
    begin
        if (step)
            prod_reg <= prod_next;
    end

    assign step_x       = XW'(step_reg);
    assign res_valid    = step && hit;
    assign res_duration = (step_x > XW'(DUR_MAX)) ? DUR_MAX : step_x[DUR_WIDTH-1:0];
    assign res_peak     = peak_reg;
    assign res_rest     = rest_reg;

endmodule

@@ sv/apd_out_skid.sv @@
// Output register with one skid entry for the result stream.
`timescale 1ns / 1ps

module apd_out_skid #(
    parameter int DATA_WIDTH = 64
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  logic [DATA_WIDTH-1:0] push_data,
    output logic                  can_push,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [DATA_WIDTH-1:0] out_data
);

    logic                  out_valid_reg;
    logic [DATA_WIDTH-1:0] out_data_reg;
    logic                  skid_valid_reg;
    logic [DATA_WIDTH-1:0] skid_data_reg;
    logic                  out_free;

    assign out_free = !out_valid_reg || out_ready;
    assign can_push = !skid_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            priority if (out_free && skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else if (out_free)
            begin
                out_valid_reg <= push;
            end
            else if (push)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                skid_valid_reg <= skid_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        priority if (out_free && skid_valid_reg)
            out_data_reg <= skid_data_reg;
        else if (out_free && push)
            out_data_reg <= push_data;
        else if (!out_free && push)
            skid_data_reg <= push_data;
        else
            out_data_reg <= out_data_reg;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

@@ sv/action_potential_duration_meter.sv @@
// Top level of the action potential duration meter.
`timescale 1ns / 1ps

// Usage:
//   sample channel: one signed membrane voltage request per accepted handshake.
//   result channel: one request per detected action potential, carrying the
//     duration in samples from the upstroke sample, the peak and resting levels.
//   cfg port: cfg_write with cfg_index / cfg_data; 0 rest_initial,
//     1 upstroke_level, 2 peak_window_steps, 3 repol_percent. Write only while
//     no sample is in flight. Writing rest_initial reloads the resting level.
// Throughput: one sample per cycle while sample ready is high; each sample
//   takes one pass of compare, 17x8 multiply and scaled compare logic
//   between the state registers; the amplitude product is registered at
//   peak window end. The result of the sample crossing the end threshold is
//   registered in the output register, or in the skid entry on a stall.
// Stall: a result waits in the output register; one more result fits in a
//   skid entry, and sample ready drops only while both are occupied.
// Reset: rst_n clears phase to search, loads register defaults and the
//   resting level, and empties the output stage. No clearing sweep.

module action_potential_duration_meter
    import apd_pkg::*;
#(
    parameter int COUNT_WIDTH  = 32,
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_write,
    input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0]  cfg_data,
    apd_sample_if.sink                 sample,
    apd_result_if.source               result
);

    localparam int RES_WIDTH = DUR_WIDTH + 2 * SAMPLE_WIDTH;

    logic                           step;
    logic                           can_push;
    logic                           res_valid;
    logic [DUR_WIDTH-1:0]           res_duration;
    logic signed [SAMPLE_WIDTH-1:0] res_peak;
    logic signed [SAMPLE_WIDTH-1:0] res_rest;
    logic [RES_WIDTH-1:0]           out_data;

    assign sample.ready = can_push;
    assign step         = sample.valid && can_push;

    apd_core #(
        .COUNT_WIDTH  (COUNT_WIDTH),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .step         (step),
        .voltage      (sample.voltage),
        .res_valid    (res_valid),
        .res_duration (res_duration),
        .res_peak     (res_peak),
        .res_rest     (res_rest)
    );

    apd_out_skid #(
        .DATA_WIDTH (RES_WIDTH)
    ) u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data ({res_duration, res_peak, res_rest}),
        .can_push  (can_push),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .out_data  (out_data)
    );

    assign result.duration_steps = out_data[RES_WIDTH-1 -: DUR_WIDTH];
    assign result.peak_level     = out_data[2*SAMPLE_WIDTH-1 -: SAMPLE_WIDTH];
    assign result.rest_level     = out_data[SAMPLE_WIDTH-1:0];

endmodule

@@ sv/apd_checker.sv @@
// Port-level assertions for the action potential duration meter, with bind.
`timescale 1ns / 1ps

module apd_checker
    import apd_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_ready,
    input logic                 out_valid,
    input logic                 out_ready,
    input logic [DUR_WIDTH-1:0] duration_steps
);

    // a held result keeps its duration
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(duration_steps))
        else $error("result changed while stalled");

    // a new result only follows an accepted sample
    a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready))
        else $error("result appeared without a sample");

    // sample backpressure only while a result waits
    a_ready_low: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("sample ready low with empty output");

    // end sample comes at least two samples after the upstroke
    a_dur_min: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> duration_steps >= DUR_WIDTH'(2))
        else $error("duration too short");

endmodule

bind action_potential_duration_meter apd_checker u_apd_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (sample.valid),
    .in_ready       (sample.ready),
    .out_valid      (result.valid),
    .out_ready      (result.ready),
    .duration_steps (result.duration_steps)
);
